### rtl/yaf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yaf_pkg
// Types, matrix coefficients and saturation helpers for the YCbCr alpha fade.
// ----------------------------------------------------------------------------
package yaf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ACC_W     = 27;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [16:0]      t_coef;

    typedef struct packed {
        logic [7:0] y_in;
        logic [7:0] u_in;
        logic [7:0] v_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] y_out;
        logic [7:0] u_out;
        logic [7:0] v_out;
    } t_pix_out;

    // Inverse matrix, limited-range BT.601, scaled by 2^14
    localparam t_coef K_Y  = 17'sd19077;
    localparam t_coef K_RV = 17'sd26149;
    localparam t_coef K_GU = -17'sd6419;
    localparam t_coef K_GV = -17'sd13320;
    localparam t_coef K_BU = 17'sd33050;

    // Forward matrix, scaled by 2^14
    localparam t_coef K_YR = 17'sd4207;
    localparam t_coef K_YG = 17'sd8260;
    localparam t_coef K_YB = 17'sd1604;
    localparam t_coef K_UR = -17'sd2428;
    localparam t_coef K_UG = -17'sd4768;
    localparam t_coef K_UB = 17'sd7196;
    localparam t_coef K_VR = 17'sd7196;
    localparam t_coef K_VG = -17'sd6026;
    localparam t_coef K_VB = -17'sd1170;

    localparam t_acc OFF_Y = t_acc'(16)  <<< FRAC_BITS;
    localparam t_acc OFF_C = t_acc'(128) <<< FRAC_BITS;

    localparam logic [8:0] ALPHA_RESET = 9'd256;

    // Negative gives 0, otherwise sum >> 14 limited to 255
    function automatic logic [7:0] sat_px(input t_acc sum);
        logic [7:0] q;
        if (sum[ACC_W-1]) begin
            q = '0;
        end else if (|sum[ACC_W-2:FRAC_BITS+8]) begin
            q = 8'hFF;
        end else begin
            q = sum[FRAC_BITS+7:FRAC_BITS];
        end
        return q;
    endfunction

    // Product of component and weight, >> 8, limited to 255
    function automatic logic [7:0] sat_fade(input logic [16:0] p);
        logic [7:0] q;
        if (p[16]) begin
            q = 8'hFF;
        end else begin
            q = p[15:8];
        end
        return q;
    endfunction

endpackage
`default_nettype wire

### rtl/yuv_alpha_fade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_alpha_fade
// Converts a YCbCr pixel to RGB, scales RGB by alpha/256, converts back.
// ----------------------------------------------------------------------------
// Takes one pixel every clock cycle and returns it through the register stages,
// marked by o_strobe for one cycle. The five register stages are: inverse
// matrix products, inverse sums with saturation, fade products, forward
// matrix products with fade saturation, forward sums with saturation. The
// receiver cannot stall; busy is high only while reset is held. Write the
// weight only while no pixel is in flight.
module yuv_alpha_fade (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire yaf_pkg::t_pix_in   i_pix,
    output logic                    o_strobe,
    output yaf_pkg::t_pix_out       o_pix,
    input  wire                     i_cfg_we,
    input  wire [8:0]               i_cfg_wdata
);

    logic                 accept;
    logic [4:0]           r_vld;
    logic [8:0]           r_alpha;

    logic signed [9:0]    d;
    logic signed [9:0]    e;
    logic signed [9:0]    f;

    yaf_pkg::t_acc        r_p_y, r_p_rv, r_p_gu, r_p_gv, r_p_bu;
    logic [7:0]           r_r, r_g, r_b;
    logic [16:0]          r_fr, r_fg, r_fb;
    logic signed [8:0]    rf, gf, bf;
    yaf_pkg::t_acc        r_p_yr, r_p_yg, r_p_yb;
    yaf_pkg::t_acc        r_p_ur, r_p_ug, r_p_ub;
    yaf_pkg::t_acc        r_p_vr, r_p_vg, r_p_vb;
    yaf_pkg::t_pix_out    r_out;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign d = $signed({2'b00, i_pix.y_in}) - 10'sd16;
    assign e = $signed({2'b00, i_pix.u_in}) - 10'sd128;
    assign f = $signed({2'b00, i_pix.v_in}) - 10'sd128;

    assign rf = $signed({1'b0, yaf_pkg::sat_fade(r_fr)});
    assign gf = $signed({1'b0, yaf_pkg::sat_fade(r_fg)});
    assign bf = $signed({1'b0, yaf_pkg::sat_fade(r_fb)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_alpha <= yaf_pkg::ALPHA_RESET;
        end else begin
            r_vld <= {r_vld[3:0], accept};
            if (i_cfg_we) begin
                r_alpha <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // inverse products
        r_p_y  <= yaf_pkg::t_acc'(d) * yaf_pkg::K_Y;
        r_p_rv <= yaf_pkg::t_acc'(f) * yaf_pkg::K_RV;
        r_p_gu <= yaf_pkg::t_acc'(e) * yaf_pkg::K_GU;
        r_p_gv <= yaf_pkg::t_acc'(f) * yaf_pkg::K_GV;
        r_p_bu <= yaf_pkg::t_acc'(e) * yaf_pkg::K_BU;
        // inverse sums
        r_r <= yaf_pkg::sat_px(r_p_y + r_p_rv);
        r_g <= yaf_pkg::sat_px(r_p_y + r_p_gu + r_p_gv);
        r_b <= yaf_pkg::sat_px(r_p_y + r_p_bu);
        // fade products
        r_fr <= 17'(r_r * r_alpha);
        r_fg <= 17'(r_g * r_alpha);
        r_fb <= 17'(r_b * r_alpha);
        // forward products
        r_p_yr <= yaf_pkg::t_acc'(rf) * yaf_pkg::K_YR;
        r_p_yg <= yaf_pkg::t_acc'(gf) * yaf_pkg::K_YG;
        r_p_yb <= yaf_pkg::t_acc'(bf) * yaf_pkg::K_YB;
        r_p_ur <= yaf_pkg::t_acc'(rf) * yaf_pkg::K_UR;
        r_p_ug <= yaf_pkg::t_acc'(gf) * yaf_pkg::K_UG;
        r_p_ub <= yaf_pkg::t_acc'(bf) * yaf_pkg::K_UB;
        r_p_vr <= yaf_pkg::t_acc'(rf) * yaf_pkg::K_VR;
        r_p_vg <= yaf_pkg::t_acc'(gf) * yaf_pkg::K_VG;
        r_p_vb <= yaf_pkg::t_acc'(bf) * yaf_pkg::K_VB;
        // forward sums
        r_out.y_out <= yaf_pkg::sat_px(r_p_yr + r_p_yg + r_p_yb + yaf_pkg::OFF_Y);
        r_out.u_out <= yaf_pkg::sat_px(r_p_ur + r_p_ug + r_p_ub + yaf_pkg::OFF_C);
        r_out.v_out <= yaf_pkg::sat_px(r_p_vr + r_p_vg + r_p_vb + yaf_pkg::OFF_C);
    end

    assign o_strobe = r_vld[4];
    assign o_pix    = r_out;

    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_strobe)
        else $error("accepted pixel did not emerge after five cycles");

    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 5))
        else $error("result strobe without a matching transaction");

    a_pipe_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept && $countones(r_vld) == 0 |=> $countones(r_vld) == 0)
        else $error("pipeline valid appeared from nothing");

endmodule
`default_nettype wire

### tb/yaf_fade_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yaf_fade_checker
// Scoreboard for the YCbCr alpha fade.
// ----------------------------------------------------------------------------
// Follows the fade weight register and every accepted pixel transaction. For
// each one it computes the faded pixel in 32-bit integer arithmetic: inverse
// BT.601 matrix, weight scaling, forward matrix, each stage clamped to
// 0..255. Results come out in order, so every strobed result is compared
// field by field against the oldest queued pixel. Reports the number of
// outstanding pixels and the number of failures.
// ----------------------------------------------------------------------------
module yaf_fade_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire                  i_busy,
    input  yaf_pkg::t_pix_in     i_pix,
    input  wire                  i_strobe,
    input  yaf_pkg::t_pix_out    i_opix,
    input  wire                  i_cfg_we,
    input  wire [8:0]            i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_cnt
);

    localparam int Q = 14;

    yaf_pkg::t_pix_out faded_q[$];
    logic [8:0]        fade_weight = 9'd256;

    function automatic logic [7:0] clamp_q14(input int sum);
        logic [7:0] q;
        if (sum < 0) begin
            q = 8'd0;
        end else if ((sum >>> Q) > 255) begin
            q = 8'd255;
        end else begin
            q = sum[Q+7:Q];
        end
        return q;
    endfunction

    function automatic int scale_component(input logic [7:0] c, input logic [8:0] w);
        int p;
        p = (int'(c) * int'(w)) >>> 8;
        return (p > 255) ? 255 : p;
    endfunction

    function automatic yaf_pkg::t_pix_out faded_pixel(input yaf_pkg::t_pix_in px,
                                                      input logic [8:0] w);
        int d, e, f, luma, rf, gf, bf;
        logic [7:0] r, g, b;
        yaf_pkg::t_pix_out res;
        d    = int'(px.y_in) - 16;
        e    = int'(px.u_in) - 128;
        f    = int'(px.v_in) - 128;
        luma = 19077 * d;
        r    = clamp_q14(luma + 26149 * f);
        g    = clamp_q14(luma - 6419 * e - 13320 * f);
        b    = clamp_q14(luma + 33050 * e);
        rf   = scale_component(r, w);
        gf   = scale_component(g, w);
        bf   = scale_component(b, w);
        res.y_out = clamp_q14(4207 * rf + 8260 * gf + 1604 * bf + (16 << Q));
        res.u_out = clamp_q14(-2428 * rf - 4768 * gf + 7196 * bf + (128 << Q));
        res.v_out = clamp_q14(7196 * rf - 6026 * gf - 1170 * bf + (128 << Q));
        return res;
    endfunction

    always @(posedge i_clk) begin
        yaf_pkg::t_pix_out want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            fade_weight = 9'd256;
            faded_q.delete();
        end else begin
            if ($isunknown(i_strobe)) begin
                $error("o_strobe unknown");
                errs++;
            end else if (i_strobe) begin
                if (faded_q.size() == 0) begin
                    $error("result %h with no pixel outstanding", i_opix);
                    errs++;
                end else begin
                    want = faded_q.pop_front();
                    if (i_opix.y_out !== want.y_out) begin
                        $error("y_out: expected %0d, actual %0d", want.y_out, i_opix.y_out);
                        errs++;
                    end
                    if (i_opix.u_out !== want.u_out) begin
                        $error("u_out: expected %0d, actual %0d", want.u_out, i_opix.u_out);
                        errs++;
                    end
                    if (i_opix.v_out !== want.v_out) begin
                        $error("v_out: expected %0d, actual %0d", want.v_out, i_opix.v_out);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                faded_q.push_back(faded_pixel(i_pix, fade_weight));
            end
            if (i_cfg_we) begin
                fade_weight = i_cfg_wdata;
            end
        end
        o_fail_cnt <= o_fail_cnt + errs;
        o_pending  <= faded_q.size();
    end

endmodule

### tb/tb_yuv_alpha_fade.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuv_alpha_fade
// Testbench for the YCbCr alpha fade pipeline.
// ----------------------------------------------------------------------------
// Drives a directed set of pixels (range corners, black, white, primaries,
// out-of-gamut chroma) at full weight, then random pixels over a series of
// fade weights: zero, one, mid, full, above full up to the 9-bit maximum and
// random values. The weight is written only once the pipeline has emptied.
// Random idle bursts vary per phase; the last phase runs back to back.
// Checking is done by yaf_fade_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_yuv_alpha_fade;

    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int N_DIRECTED  = 20;
    localparam int CYCLE_LIMIT = 200000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    yaf_pkg::t_pix_in  i_pix       = '0;
    logic              o_strobe;
    yaf_pkg::t_pix_out o_pix;
    logic              i_cfg_we    = 1'b0;
    logic [8:0]        i_cfg_wdata = '0;

    int pending;
    int fail_cnt;
    int cycle_cnt = 0;
    int pixels_sent = 0;

    always #2 i_clk = ~i_clk;

    yuv_alpha_fade i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pix       (i_pix),
        .o_strobe    (o_strobe),
        .o_pix       (o_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    yaf_fade_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_pix       (i_pix),
        .i_strobe    (o_strobe),
        .i_opix      (o_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_fail_cnt  (fail_cnt)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_pixel(input yaf_pkg::t_pix_in px);
        i_pix <= px;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pixels_sent++;
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [8:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_sample();
        logic [7:0] s;
        case ($urandom_range(0, 7))
            0: s = 8'd0;
            1: s = 8'd255;
            2: s = 8'd16;
            3: s = 8'd235;
            4: s = 8'd240;
            default: s = 8'($urandom_range(0, 255));
        endcase
        return s;
    endfunction

    initial begin
        yaf_pkg::t_pix_in directed[N_DIRECTED];
        logic [8:0] fixed_w[8];
        logic [8:0] w;
        yaf_pkg::t_pix_in px;
        int idle_pct;

        directed = '{
            '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
            '{8'd16,  8'd128, 8'd128}, '{8'd235, 8'd128, 8'd128},
            '{8'd0,   8'd128, 8'd128}, '{8'd255, 8'd128, 8'd128},
            '{8'd16,  8'd16,  8'd16},  '{8'd16,  8'd240, 8'd240},
            '{8'd235, 8'd16,  8'd240}, '{8'd235, 8'd240, 8'd16},
            '{8'd128, 8'd0,   8'd255}, '{8'd128, 8'd255, 8'd0},
            '{8'd81,  8'd90,  8'd240}, '{8'd145, 8'd54,  8'd34},
            '{8'd41,  8'd240, 8'd110}, '{8'd210, 8'd16,  8'd146},
            '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd255},
            '{8'd16,  8'd255, 8'd0},   '{8'd16,  8'd0,   8'd255}
        };
        fixed_w = '{9'd0, 9'd511, 9'd1, 9'd257, 9'd128, 9'd255, 9'd256, 9'd64};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_weight(9'd256);
        foreach (directed[k]) begin
            send_pixel(directed[k]);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_pipeline();
            if (p < 8) begin
                w = fixed_w[p];
            end else if (p % 2 == 0) begin
                w = 9'($urandom_range(0, 256));
            end else begin
                w = 9'($urandom_range(0, 511));
            end
            write_weight(w);
            idle_pct = (p == N_PHASES - 1) ? 0 : (p % 3) * 25;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(1, 100) <= idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
                px.y_in = pick_sample();
                px.u_in = pick_sample();
                px.v_in = pick_sample();
                send_pixel(px);
            end
        end

        drain_pipeline();
        repeat (10) @(posedge i_clk);

        $display("sent %0d pixel transactions: %0d directed, then %0d weight phases",
                 pixels_sent, N_DIRECTED, N_PHASES);
        $display("weights covered zero, one, mid, full, above full to 511 and random");
        if (fail_cnt == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
